@@ rtl/core/wrmt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmt_pkg
// Shared constants and codes for the wrapping range match table.
// ----------------------------------------------------------------------------
package wrmt_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;
	localparam int DIST_BITS_DEF     = 16;
	localparam int VALUE_BITS        = 32;
	localparam int OPCODE_BITS       = 2;

	typedef logic [OPCODE_BITS-1:0] opcode_t;

	localparam opcode_t OP_LOOKUP = 2'd0;
	localparam opcode_t OP_INSERT = 2'd1;
	localparam opcode_t OP_CLEAR  = 2'd2;

endpackage

@@ rtl/core/wrmt_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmt_req_if
// Request channel: opcode and operands of one command beat.
// ----------------------------------------------------------------------------
interface wrmt_req_if
	import wrmt_pkg::*;
#(
	parameter int DIST_BITS = DIST_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	opcode_t                      opcode;
	logic [DIST_BITS-1:0]         query_distance;
	logic [DIST_BITS-1:0]         range_start;
	logic [DIST_BITS-1:0]         range_end;
	logic signed [VALUE_BITS-1:0] new_value;

	modport source (
		output valid, opcode, query_distance, range_start, range_end, new_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, query_distance, range_start, range_end, new_value,
		output ready
	);
endinterface

@@ rtl/core/wrmt_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmt_rsp_if
// Response channel: one result beat per command.
// ----------------------------------------------------------------------------
interface wrmt_rsp_if
	import wrmt_pkg::*;
;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic signed [VALUE_BITS-1:0] found_value;
	logic                         rejected;

	modport source (
		output valid, hit, found_value, rejected,
		input  ready
	);
	modport sink (
		input  valid, hit, found_value, rejected,
		output ready
	);
endinterface

@@ rtl/core/wrmt_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmt_store
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wrmt_store #(
	parameter int DEPTH  = 32,
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/core/wrmt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrmt_ctrl
// Command sequencer: appends entries, clears the table, walks the memory in
// order for a lookup, and holds the result in an output register.
// ----------------------------------------------------------------------------
module wrmt_ctrl
	import wrmt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int DIST_BITS     = DIST_BITS_DEF,
	parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	parameter int WORD_W        = 2 * DIST_BITS + VALUE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	wrmt_req_if.sink         req,
	wrmt_rsp_if.source       rsp,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output logic [WORD_W-1:0] mem_wdata,
	output logic             mem_re,
	output logic [IDX_W-1:0] mem_raddr,
	input  logic [WORD_W-1:0] mem_rdata
);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_PEND = 3'b100
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             count_q;
	logic [IDX_W-1:0]             idx_q;
	logic                         out_valid_q;
	logic [DIST_BITS-1:0]         qdist_q;
	logic                         res_hit_q;
	logic signed [VALUE_BITS-1:0] res_val_q;
	logic                         res_rej_q;
	logic                         out_hit_q;
	logic signed [VALUE_BITS-1:0] out_val_q;
	logic                         out_rej_q;

	logic                         accept;
	logic                         full;
	logic                         last;
	logic                         match;
	logic                         out_free;
	logic [DIST_BITS-1:0]         rd_start;
	logic [DIST_BITS-1:0]         rd_end;
	logic signed [VALUE_BITS-1:0] rd_value;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(TABLE_ENTRIES));
	assign last      = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign out_free  = !out_valid_q || rsp.ready;

	assign rd_start = mem_rdata[WORD_W-1 -: DIST_BITS];
	assign rd_end   = mem_rdata[VALUE_BITS +: DIST_BITS];
	assign rd_value = mem_rdata[VALUE_BITS-1:0];

	// start not below end wraps round the lap
	always_comb begin
		if (rd_start < rd_end) begin
			match = (qdist_q >= rd_start) && (qdist_q <= rd_end);
		end else begin
			match = (qdist_q >= rd_start) || (qdist_q <= rd_end);
		end
	end

	// writes only happen on accept in idle; reads happen on accept and while scanning
	assign mem_we    = accept && (req.opcode == OP_INSERT) && !full;
	assign mem_waddr = count_q[IDX_W-1:0];
	assign mem_wdata = {req.range_start, req.range_end, req.new_value};
	assign mem_re    = accept || (state_q == ST_SCAN);
	assign mem_raddr = (state_q == ST_SCAN) ? idx_q + IDX_W'(1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_PEND) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						unique case (req.opcode)
							OP_LOOKUP: begin
								state_q <= (count_q != '0) ? ST_SCAN : ST_PEND;
							end
							OP_INSERT: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= ST_PEND;
							end
							OP_CLEAR: begin
								count_q <= '0;
								state_q <= ST_PEND;
							end
							default: begin
								state_q <= ST_PEND;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (match || last) begin
						state_q <= ST_PEND;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_PEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qdist_q   <= req.query_distance;
			res_hit_q <= 1'b0;
			res_val_q <= '0;
			res_rej_q <= (req.opcode == OP_INSERT) && full;
		end else if ((state_q == ST_SCAN) && match) begin
			res_hit_q <= 1'b1;
			res_val_q <= rd_value;
		end
		if ((state_q == ST_PEND) && out_free) begin
			out_hit_q <= res_hit_q;
			out_val_q <= res_val_q;
			out_rej_q <= res_rej_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.found_value = out_val_q;
	assign rsp.rejected    = out_rej_q;
endmodule

@@ rtl/core/wrapping_range_match_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapping_range_match_table_core
// Ordered table of distance ranges with append, first-match lookup and clear.
// ----------------------------------------------------------------------------
// One command is handled at a time. Insert, clear and the unused opcode go
// straight from accept to the pending state and then to the result beat; a
// lookup walks the entry memory one entry per cycle through its single read
// port, up to the first matching entry, or over all entries on a miss, and
// skips the walk on an empty table. The result sits in an output register, so
// a new command is taken while the previous beat waits. No clearing pass after
// reset: entries past the count never affect a result.
module wrapping_range_match_table_core
	import wrmt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int DIST_BITS     = DIST_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wrmt_req_if.sink   req,
	wrmt_rsp_if.source rsp
);
	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int WORD_W = 2 * DIST_BITS + VALUE_BITS;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	wrmt_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.DIST_BITS     (DIST_BITS),
		.IDX_W         (IDX_W),
		.WORD_W        (WORD_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	wrmt_store #(
		.DEPTH  (TABLE_ENTRIES),
		.WIDTH  (WORD_W),
		.ADDR_W (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);
endmodule
